@@ rtl/tmac_pkg.sv @@
`timescale 1ns / 1ps
package tmac_pkg;

   // group and table sizing
   localparam int SAMPLES    = 7;
   localparam int CHANNELS   = 8;
   localparam int OUT_MIN    = 0;
   localparam int OUT_MAX    = 1023;
   localparam int DROPPED    = 2;
   localparam int SAMPLE_TOP = 1023;

   // request word kinds
   localparam logic ACT_CAL    = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   // field widths
   localparam int SAMPLE_W = 10;
   localparam int CHAN_W   = 3;
   localparam int VAL_W    = 21;

   // derived widths
   localparam int CNT_W  = $clog2(SAMPLES + 1);
   localparam int SUM_W  = $clog2(SAMPLES * SAMPLE_TOP + 1);
   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int DVD_W  = 20;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   // mean by reciprocal multiply, exact for every trimmed sum
   localparam int KEPT       = SAMPLES - DROPPED;
   localparam int MEAN_SHIFT = 18;
   localparam int MEAN_RECIP = (2 ** MEAN_SHIFT + KEPT - 1) / KEPT;
   localparam int RECIP_W    = MEAN_SHIFT + 1;
   localparam int MPROD_W    = SUM_W + RECIP_W;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIM,
      ST_MAP,
      ST_CHECK,
      ST_MAP_DIV,
      ST_DONE
   } tmac_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic acc_en;
      logic cal_wr;
      logic trim_start;
      logic map_load;
      logic map_div_start;
      logic out_load;
   } tmac_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic last_sample;
      logic div_done;
      logic span_zero;
      logic out_free;
   } tmac_sts_type;

endpackage

@@ rtl/tmac_div.sv @@
`timescale 1ns / 1ps
module tmac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tmac_pkg::DVD_W-1:0]    dividend,
   input  logic [tmac_pkg::SAMPLE_W-1:0] divisor,
   output logic                          done,
   output logic [tmac_pkg::DVD_W-1:0]    quotient
);

   localparam int DvdW  = tmac_pkg::DVD_W;
   localparam int DivW  = tmac_pkg::SAMPLE_W;
   localparam int DcntW = tmac_pkg::DCNT_W;

   logic [DvdW-1:0]  quo_ff, quo_in;
   logic [DivW-1:0]  rem_ff, rem_in;
   logic [DivW-1:0]  dvs_ff, dvs_in;
   logic [DcntW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DivW:0]    shifted;
   logic [DivW:0]    trial;

   // one restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      shifted = {rem_ff, quo_ff[DvdW-1]};
      trial   = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DcntW'(DvdW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = trial[DivW-1:0];
            quo_in = {quo_ff[DvdW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DivW-1:0];
            quo_in = {quo_ff[DvdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DcntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/tmac_dp.sv @@
`timescale 1ns / 1ps
module tmac_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tmac_pkg::CHAN_W-1:0]   req_channel,
   input  logic [tmac_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [tmac_pkg::SAMPLE_W-1:0] req_cal_low,
   input  logic [tmac_pkg::SAMPLE_W-1:0] req_cal_high,
   input  tmac_pkg::tmac_cmd_type        cmd,
   output tmac_pkg::tmac_sts_type        sts,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [tmac_pkg::VAL_W-1:0] rsp_value,
   output logic [tmac_pkg::CHAN_W-1:0]   rsp_out_channel,
   output logic                          rsp_span_error
);

   localparam int CntW    = tmac_pkg::CNT_W;
   localparam int SumW    = tmac_pkg::SUM_W;
   localparam int SampleW = tmac_pkg::SAMPLE_W;
   localparam int ChanW   = tmac_pkg::CHAN_W;
   localparam int DiffW   = tmac_pkg::DIFF_W;
   localparam int ProdW   = tmac_pkg::PROD_W;
   localparam int DvdW    = tmac_pkg::DVD_W;
   localparam int ValW    = tmac_pkg::VAL_W;
   localparam int Chans   = tmac_pkg::CHANNELS;
   localparam int MprodW  = tmac_pkg::MPROD_W;

   // running group
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic [SampleW-1:0] min_ff, min_in;
   logic [SampleW-1:0] max_ff, max_in;
   logic [ChanW-1:0]   chan_ff;

   // calibration tables
   logic [SampleW-1:0] cal_low_ff  [Chans];
   logic [SampleW-1:0] cal_high_ff [Chans];

   // trimmed mean
   logic [SampleW-1:0] mean_ff;

   // mapping stage
   logic [DvdW-1:0]    num_mag_ff;
   logic [SampleW-1:0] den_mag_ff;
   logic               neg_ff;
   logic               span_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [ValW-1:0] rsp_value_ff;
   logic [ChanW-1:0]       rsp_chan_ff;
   logic                   rsp_err_ff;

   // divider hookup
   logic                div_start;
   logic [DvdW-1:0]     div_dividend;
   logic [SampleW-1:0]  div_divisor;
   logic                div_done;
   logic [DvdW-1:0]     div_quo;

   logic [SumW-1:0]        trimmed;
   logic [MprodW-1:0]      mean_prod;
   logic [SampleW-1:0]     low_sel;
   logic [SampleW-1:0]     high_sel;
   logic signed [DiffW-1:0] num_diff;
   logic signed [DiffW-1:0] den_diff;
   logic signed [ProdW-1:0] scale;
   logic signed [ProdW-1:0] prod;
   logic signed [ProdW-1:0] prod_mag;
   logic signed [DiffW-1:0] den_abs;
   logic signed [ValW-1:0]  quo_s;
   logic signed [ValW-1:0]  res_s;

   // accumulate sum, minimum and maximum; cleared when the group closes
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.trim_start) begin
         cnt_in = '0;
         sum_in = '0;
         min_in = SampleW'(tmac_pkg::SAMPLE_TOP);
         max_in = '0;
      end else if (cmd.acc_en) begin
         cnt_in = cnt_ff + 1'b1;
         sum_in = sum_ff + SumW'(req_sample);
         if (req_sample < min_ff) begin
            min_in = req_sample;
         end
         if (req_sample > max_ff) begin
            max_in = req_sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         min_ff <= SampleW'(tmac_pkg::SAMPLE_TOP);
         max_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         sum_ff <= sum_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // channel of the latest sample, the closing one selects the calibration
   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         chan_ff <= req_channel;
      end
   end

   // calibration pair write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Chans; i++) begin
            cal_low_ff[i]  <= '0;
            cal_high_ff[i] <= SampleW'(tmac_pkg::SAMPLE_TOP);
         end
      end else if (cmd.cal_wr) begin
         cal_low_ff[req_channel]  <= req_cal_low;
         cal_high_ff[req_channel] <= req_cal_high;
      end
   end

   // trimmed sum over the kept count, by reciprocal multiply and shift
   assign trimmed   = sum_ff - SumW'(min_ff) - SumW'(max_ff);
   assign mean_prod = MprodW'(trimmed) * MprodW'(tmac_pkg::MEAN_RECIP);

   always_ff @(posedge clock) begin
      if (cmd.trim_start) begin
         mean_ff <= mean_prod[tmac_pkg::MEAN_SHIFT +: SampleW];
      end
   end

   // divider for the mapping
   assign div_start    = cmd.map_div_start;
   assign div_dividend = num_mag_ff;
   assign div_divisor  = den_mag_ff;

   tmac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // linear map numerator and span, split into magnitude and sign
   always_comb begin
      low_sel  = cal_low_ff[chan_ff];
      high_sel = cal_high_ff[chan_ff];
      num_diff = $signed({1'b0, mean_ff}) - $signed({1'b0, low_sel});
      den_diff = $signed({1'b0, high_sel}) - $signed({1'b0, low_sel});
      scale    = ProdW'(tmac_pkg::OUT_MAX - tmac_pkg::OUT_MIN);
      prod     = ProdW'(num_diff) * scale;
      prod_mag = prod[ProdW-1] ? -prod : prod;
      den_abs  = den_diff[DiffW-1] ? -den_diff : den_diff;
   end

   always_ff @(posedge clock) begin
      if (cmd.map_load) begin
         num_mag_ff <= prod_mag[DvdW-1:0];
         den_mag_ff <= den_abs[SampleW-1:0];
         neg_ff     <= prod[ProdW-1] ^ den_diff[DiffW-1];
         span_ff    <= (den_diff == '0);
      end
   end

   // signed quotient, truncated toward zero
   always_comb begin
      quo_s = $signed({1'b0, div_quo});
      res_s = neg_ff ? -quo_s : quo_s;
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff <= span_ff ? ValW'(tmac_pkg::OUT_MIN) :
                         res_s + ValW'(tmac_pkg::OUT_MIN);
         rsp_chan_ff  <= chan_ff;
         rsp_err_ff   <= span_ff;
      end
   end

   // status back to the controller
   assign sts.last_sample = (cnt_ff == CntW'(tmac_pkg::SAMPLES - 1));
   assign sts.div_done    = div_done;
   assign sts.span_zero   = span_ff;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_span_error  = rsp_err_ff;

endmodule

@@ rtl/tmac_ctrl.sv @@
`timescale 1ns / 1ps
module tmac_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_stall,
   input  tmac_pkg::tmac_sts_type sts,
   output tmac_pkg::tmac_cmd_type cmd
);

   tmac_pkg::tmac_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tmac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         tmac_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == tmac_pkg::ACT_SAMPLE) begin
                  cmd.acc_en = 1'b1;
                  if (sts.last_sample) begin
                     state_in = tmac_pkg::ST_TRIM;
                  end
               end else begin
                  cmd.cal_wr = 1'b1;
               end
            end
         end
         tmac_pkg::ST_TRIM: begin
            cmd.trim_start = 1'b1;
            state_in       = tmac_pkg::ST_MAP;
         end
         tmac_pkg::ST_MAP: begin
            cmd.map_load = 1'b1;
            state_in     = tmac_pkg::ST_CHECK;
         end
         tmac_pkg::ST_CHECK: begin
            if (sts.span_zero) begin
               state_in = tmac_pkg::ST_DONE;
            end else begin
               cmd.map_div_start = 1'b1;
               state_in          = tmac_pkg::ST_MAP_DIV;
            end
         end
         tmac_pkg::ST_MAP_DIV: begin
            if (sts.div_done) begin
               state_in = tmac_pkg::ST_DONE;
            end
         end
         tmac_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = tmac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tmac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/trimmed_mean_adc_calibrator.sv @@
`timescale 1ns / 1ps
// Trimmed-mean averager with per-channel linear calibration.
// Request channel (req_valid / req_stall): each word either writes a
// calibration low/high pair for req_channel (req_action = 0) or delivers one
// raw sample (req_action = 1). Samples of any channel build one group; the
// seventh sample closes it, the largest and smallest are dropped, the rest is
// averaged and mapped through the pair of the closing sample's channel.
// Response channel (rsp_valid / rsp_stall): one word per closed group with the
// signed value, the closing channel and a flag for a zero calibration span.
// Throughput: calibration writes and samples that do not close a group are
// taken at one per cycle. A closing sample keeps the request side stalled: the
// mean comes from a reciprocal multiply, then a restoring divider scales it at
// one bit per cycle (skipped when the span is zero); the word waits for a free
// response register, and requests are taken again once it appears.
// The response register holds one finished word, so new requests are taken
// while it waits; a second closed group waits for the first to be taken.
// A stalled response word holds its value. Reset (synchronous, active high)
// clears the running group, sets every calibration pair to low 0 / high 1023
// and drops any pending response.
module trimmed_mean_adc_calibrator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [tmac_pkg::CHAN_W-1:0]   req_channel,
   input  logic [tmac_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [tmac_pkg::SAMPLE_W-1:0] req_cal_low,
   input  logic [tmac_pkg::SAMPLE_W-1:0] req_cal_high,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [tmac_pkg::VAL_W-1:0] rsp_value,
   output logic [tmac_pkg::CHAN_W-1:0]   rsp_out_channel,
   output logic                          rsp_span_error
);

   tmac_pkg::tmac_cmd_type cmd;
   tmac_pkg::tmac_sts_type sts;

   // sequencer
   tmac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   // accumulators, tables, divider and response register
   tmac_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .req_cal_low     (req_cal_low),
      .req_cal_high    (req_cal_high),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value),
      .rsp_out_channel (rsp_out_channel),
      .rsp_span_error  (rsp_span_error)
   );

endmodule

@@ rtl/tmac_chk.sv @@
`timescale 1ns / 1ps
module tmac_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_action,
   input logic [tmac_pkg::CHAN_W-1:0]   req_channel,
   input logic [tmac_pkg::SAMPLE_W-1:0] req_sample,
   input logic [tmac_pkg::SAMPLE_W-1:0] req_cal_low,
   input logic [tmac_pkg::SAMPLE_W-1:0] req_cal_high,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [tmac_pkg::VAL_W-1:0] rsp_value,
   input logic [tmac_pkg::CHAN_W-1:0]   rsp_out_channel,
   input logic                          rsp_span_error
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_out_channel) && $stable(rsp_span_error))
      else $error("response word changed while stalled");

   // reset drops any pending response
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a zero span forces the minimum output
   a_span_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_error |-> rsp_value == tmac_pkg::VAL_W'(tmac_pkg::OUT_MIN))
      else $error("span error with non-minimum value");

   // a new response only comes out of the busy phase of a closing sample
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared while requests were open");

endmodule

bind trimmed_mean_adc_calibrator tmac_chk u_tmac_chk (.*);
